[src/wmms_pkg.sv]
// ----------------------------------------------------------------------------
// wmms_pkg: shared types and constants
// Opcodes, error codes, register indexes, the statistic unit record and the
// result record of the windowed min/max/sum monitor.
// ----------------------------------------------------------------------------
package wmms_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int TAG_W    = 8;
  localparam int TICK_W   = 32;
  localparam int COUNT_W  = 40;
  localparam int SUM_W    = 64;
  localparam int IDX_W    = 2;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [TICK_W-1:0] TIMEOUT_SHORT_RST = 32'd2;
  localparam logic [TICK_W-1:0] TIMEOUT_LONG_RST  = 32'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LONG  = 2'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE      = 3'd0,
    OP_TIMER_START = 3'd1,
    OP_TIMER_STOP  = 3'd2,
    OP_ROTATE      = 3'd3,
    OP_READ        = 3'd4
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_RUNNING     = 2'd1,
    ERR_NOT_RUNNING = 2'd2
  } err_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] sample_value;
    logic [TAG_W-1:0]          sample_tag;
    logic [TICK_W-1:0]         now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic [SUM_W-1:0]          sum;
    logic signed [VALUE_W-1:0] min_v;
    logic signed [VALUE_W-1:0] max_v;
    logic [TAG_W-1:0]          min_tag;
    logic [TAG_W-1:0]          max_tag;
    logic [TICK_W-1:0]         start;
  } unit_t;

  localparam unit_t UNIT_CLEAR = '{
    count:   '0,
    sum:     '0,
    min_v:   VALUE_MAX,
    max_v:   VALUE_MIN,
    min_tag: '0,
    max_tag: '0,
    start:   '0
  };

  typedef struct packed {
    logic                      rec;
    logic                      rot;
    logic signed [VALUE_W-1:0] value;
    logic [TAG_W-1:0]          tag;
    logic [TICK_W-1:0]         now;
  } unit_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]          unit_index;
    logic [COUNT_W-1:0]        sample_count;
    logic signed [SUM_W-1:0]   value_sum;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic [TAG_W-1:0]          min_tag;
    logic [TAG_W-1:0]          max_tag;
    logic [TICK_W-1:0]         age_ticks;
    logic                      age_valid;
    logic [ERR_W-1:0]          error_code;
    logic                      last_result;
  } res_t;

  function automatic unit_t unit_record(unit_t u, logic signed [VALUE_W-1:0] v,
                                        logic [TAG_W-1:0] tag);
    unit_t r;
    r = u;
    if (u.count != COUNT_MAX) r.count = u.count + COUNT_W'(1);
    r.sum = u.sum + {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
    if ($signed(v) < $signed(u.min_v)) begin
      r.min_v   = v;
      r.min_tag = tag;
    end
    if ($signed(v) > $signed(u.max_v)) begin
      r.max_v   = v;
      r.max_tag = tag;
    end
    return r;
  endfunction

  function automatic res_t status_res(err_t err);
    res_t r;
    r = '0;
    r.error_code  = err;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic res_t unit_res(unit_t u, logic [IDX_W-1:0] idx,
                                    logic [TICK_W-1:0] now, logic last);
    res_t r;
    r.unit_index   = idx;
    r.sample_count = u.count;
    r.value_sum    = u.sum;
    r.min_value    = u.min_v;
    r.max_value    = u.max_v;
    r.min_tag      = u.min_tag;
    r.max_tag      = u.max_tag;
    r.age_valid    = (u.start != '0);
    r.age_ticks    = r.age_valid ? (now - u.start) : '0;
    r.error_code   = ERR_OK;
    r.last_result  = last;
    return r;
  endfunction

endpackage

[src/wmms_if.sv]
// ----------------------------------------------------------------------------
// wmms_if: channel interfaces
// Input, result and register write channels, each valid/ready with payload.
// ----------------------------------------------------------------------------
interface wmms_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [wmms_pkg::OPCODE_W-1:0]               opcode;
  logic signed [wmms_pkg::VALUE_W-1:0]         sample_value;
  logic [wmms_pkg::TAG_W-1:0]                  sample_tag;
  logic [wmms_pkg::TICK_W-1:0]                 now_ticks;

  modport source (output valid, opcode, sample_value, sample_tag, now_ticks,
                  input ready);
  modport sink   (input valid, opcode, sample_value, sample_tag, now_ticks,
                  output ready);
endinterface

interface wmms_out_if;
  logic                                        valid;
  logic                                        ready;
  logic [wmms_pkg::IDX_W-1:0]                  unit_index;
  logic [wmms_pkg::COUNT_W-1:0]                sample_count;
  logic signed [wmms_pkg::SUM_W-1:0]           value_sum;
  logic signed [wmms_pkg::VALUE_W-1:0]         min_value;
  logic signed [wmms_pkg::VALUE_W-1:0]         max_value;
  logic [wmms_pkg::TAG_W-1:0]                  min_tag;
  logic [wmms_pkg::TAG_W-1:0]                  max_tag;
  logic [wmms_pkg::TICK_W-1:0]                 age_ticks;
  logic                                        age_valid;
  logic [wmms_pkg::ERR_W-1:0]                  error_code;
  logic                                        last_result;

  modport source (output valid, unit_index, sample_count, value_sum, min_value,
                  max_value, min_tag, max_tag, age_ticks, age_valid,
                  error_code, last_result,
                  input ready);
  modport sink   (input valid, unit_index, sample_count, value_sum, min_value,
                  max_value, min_tag, max_tag, age_ticks, age_valid,
                  error_code, last_result,
                  output ready);
endinterface

interface wmms_cfg_if;
  logic                                        valid;
  logic                                        ready;
  logic [wmms_pkg::CFG_IDX_W-1:0]              index;
  logic [wmms_pkg::CFG_DATA_W-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/wmms_units.sv]
// ----------------------------------------------------------------------------
// wmms_units: statistic unit bank
// Overall unit plus previous/current halves per window. Records a sample into
// every unit, rotates windows whose timeout has passed, and shows the
// overall unit and each previous half.
// ----------------------------------------------------------------------------
module wmms_units #(
  parameter int NUM_WINDOWS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wmms_pkg::unit_cmd_t           cmd,
  input  logic [wmms_pkg::TICK_W-1:0]   timeout_short,
  input  logic [wmms_pkg::TICK_W-1:0]   timeout_long,
  output wmms_pkg::unit_t               view [NUM_WINDOWS+1]
);

  localparam int NUM_UNITS = 1 + 2 * NUM_WINDOWS;

  wmms_pkg::unit_t unit_r   [NUM_UNITS];
  wmms_pkg::unit_t unit_nxt [NUM_UNITS];
  logic            due      [NUM_WINDOWS];

  // 33-bit compare so start + timeout cannot wrap
  always_comb begin
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      logic [wmms_pkg::TICK_W:0] deadline;
      deadline = {1'b0, unit_r[2+2*w].start} +
                 {1'b0, (w == 0) ? timeout_short : timeout_long};
      due[w] = (deadline <= {1'b0, cmd.now});
    end
  end

  always_comb begin
    for (int u = 0; u < NUM_UNITS; u++) begin
      unit_nxt[u] = unit_r[u];
      if (cmd.rec) unit_nxt[u] = wmms_pkg::unit_record(unit_r[u], cmd.value, cmd.tag);
    end
    if (cmd.rot) begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        if (due[w]) begin
          unit_nxt[1+2*w]       = unit_r[2+2*w];
          unit_nxt[2+2*w]       = wmms_pkg::UNIT_CLEAR;
          unit_nxt[2+2*w].start = cmd.now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < NUM_UNITS; u++) unit_r[u] <= wmms_pkg::UNIT_CLEAR;
    end else begin
      for (int u = 0; u < NUM_UNITS; u++) unit_r[u] <= unit_nxt[u];
    end
  end

  always_comb begin
    view[0] = unit_r[0];
    for (int w = 0; w < NUM_WINDOWS; w++) view[w+1] = unit_r[1+2*w];
  end

endmodule

[src/windowed_min_max_sum_monitor_core.sv]
// ----------------------------------------------------------------------------
// windowed_min_max_sum_monitor_core: windowed statistics monitor
// An item is registered in the input stage and executed once it may go; its
// first result is then registered in the result buffer and shown on the output.
// Throughput: 1 item per cycle; a status or read item waits for the result
// buffer, so after a read the input stalls while the read's results drain.
// Reset (synchronous, rst_n low): units cleared, timer idle, timeouts 2 / 10.
// ----------------------------------------------------------------------------
module windowed_min_max_sum_monitor_core #(
  parameter int NUM_WINDOWS = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  wmms_in_if.sink       in_ch,
  wmms_out_if.source    out_ch,
  wmms_cfg_if.sink      cfg_ch
);

  localparam int NUM_RES = NUM_WINDOWS + 1;
  localparam int CNT_W   = $clog2(NUM_RES + 1);

  // register file
  logic [wmms_pkg::TICK_W-1:0] timeout_short_r, timeout_long_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_short_r <= wmms_pkg::TIMEOUT_SHORT_RST;
      timeout_long_r  <= wmms_pkg::TIMEOUT_LONG_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        wmms_pkg::CFG_TIMEOUT_SHORT: timeout_short_r <= cfg_ch.data;
        wmms_pkg::CFG_TIMEOUT_LONG:  timeout_long_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input stage
  logic                 in_v_r;
  wmms_pkg::in_item_t   in_r;
  logic                 exec;

  assign in_ch.ready = !in_v_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (exec) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.opcode       <= in_ch.opcode;
      in_r.sample_value <= in_ch.sample_value;
      in_r.sample_tag   <= in_ch.sample_tag;
      in_r.now_ticks    <= in_ch.now_ticks;
    end
  end

  // unit bank
  wmms_pkg::unit_cmd_t cmd;
  wmms_pkg::unit_t     view [NUM_RES];

  wmms_units #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_units (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .timeout_short (timeout_short_r),
    .timeout_long  (timeout_long_r),
    .view          (view)
  );

  // result buffer: entry 0 is on the output
  wmms_pkg::res_t    res_r   [NUM_RES];
  wmms_pkg::res_t    res_nxt [NUM_RES];
  wmms_pkg::res_t    new_res [NUM_RES];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, new_cnt;
  logic              pop, buf_free, need_buf, load;

  // timer
  logic                        running_r, running_nxt;
  logic [wmms_pkg::TICK_W-1:0] tstart_r, tstart_nxt;
  logic [wmms_pkg::TICK_W-1:0] elapsed;

  assign pop      = out_ch.valid && out_ch.ready;
  assign buf_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign need_buf = (in_r.opcode == wmms_pkg::OP_TIMER_START) ||
                    (in_r.opcode == wmms_pkg::OP_TIMER_STOP) ||
                    (in_r.opcode == wmms_pkg::OP_READ);
  assign exec     = in_v_r && (!need_buf || buf_free);
  assign load     = exec && need_buf;
  assign elapsed  = in_r.now_ticks - tstart_r;

  always_comb begin
    cmd.rec     = 1'b0;
    cmd.rot     = 1'b0;
    cmd.value   = in_r.sample_value;
    cmd.tag     = in_r.sample_tag;
    cmd.now     = in_r.now_ticks;
    new_cnt     = CNT_W'(1);
    running_nxt = running_r;
    tstart_nxt  = tstart_r;
    for (int i = 0; i < NUM_RES; i++) new_res[i] = '0;
    new_res[0] = wmms_pkg::status_res(wmms_pkg::ERR_OK);

    case (wmms_pkg::opcode_t'(in_r.opcode))
      wmms_pkg::OP_SAMPLE: begin
        cmd.rec = exec;
      end
      wmms_pkg::OP_TIMER_START: begin
        if (running_r) begin
          new_res[0] = wmms_pkg::status_res(wmms_pkg::ERR_RUNNING);
        end else if (exec) begin
          running_nxt = 1'b1;
          tstart_nxt  = in_r.now_ticks;
        end
      end
      wmms_pkg::OP_TIMER_STOP: begin
        // elapsed time saturates at the largest signed value
        cmd.value = elapsed[wmms_pkg::TICK_W-1] ? wmms_pkg::VALUE_MAX : elapsed;
        if (!running_r) begin
          new_res[0] = wmms_pkg::status_res(wmms_pkg::ERR_NOT_RUNNING);
        end else if (exec) begin
          cmd.rec     = 1'b1;
          running_nxt = 1'b0;
        end
      end
      wmms_pkg::OP_ROTATE: begin
        cmd.rot = exec;
      end
      wmms_pkg::OP_READ: begin
        new_cnt  = CNT_W'(NUM_RES);
        for (int i = 0; i < NUM_RES; i++) begin
          new_res[i] = wmms_pkg::unit_res(view[i], wmms_pkg::IDX_W'(i),
                                          in_r.now_ticks, i == NUM_RES - 1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      tstart_r  <= '0;
    end else begin
      running_r <= running_nxt;
      tstart_r  <= tstart_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < NUM_RES; i++) res_nxt[i] = res_r[i];
    if (pop) begin
      for (int i = 0; i < NUM_RES - 1; i++) res_nxt[i] = res_r[i+1];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    // load only happens once the buffer is empty or draining its last entry
    if (load) begin
      for (int i = 0; i < NUM_RES; i++) res_nxt[i] = new_res[i];
      cnt_nxt = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_RES; i++) res_r[i] <= res_nxt[i];
  end

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.unit_index   = res_r[0].unit_index;
  assign out_ch.sample_count = res_r[0].sample_count;
  assign out_ch.value_sum    = res_r[0].value_sum;
  assign out_ch.min_value    = res_r[0].min_value;
  assign out_ch.max_value    = res_r[0].max_value;
  assign out_ch.min_tag      = res_r[0].min_tag;
  assign out_ch.max_tag      = res_r[0].max_tag;
  assign out_ch.age_ticks    = res_r[0].age_ticks;
  assign out_ch.age_valid    = res_r[0].age_valid;
  assign out_ch.error_code   = res_r[0].error_code;
  assign out_ch.last_result  = res_r[0].last_result;

endmodule

[src/wmms_checker.sv]
// ----------------------------------------------------------------------------
// wmms_checker: port-level checks
// Watches the result channel of the monitor core over time.
// ----------------------------------------------------------------------------
module wmms_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [wmms_pkg::IDX_W-1:0]        unit_index,
  input logic [wmms_pkg::COUNT_W-1:0]      sample_count,
  input logic [wmms_pkg::TICK_W-1:0]       age_ticks,
  input logic                              age_valid,
  input logic [wmms_pkg::ERR_W-1:0]        error_code,
  input logic                              last_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(unit_index) &&
    $stable(sample_count) && $stable(error_code) && $stable(last_result))
    else $error("result changed while stalled");

  // results of one read come out without gaps
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result |=> out_valid)
    else $error("gap inside a read burst");

  // an error status is a single, all-zero result
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code != '0) |->
    last_result && (unit_index == '0) && (sample_count == '0) && !age_valid)
    else $error("malformed error status");

  // overall unit never has an age; age is zero when not valid
  a_age: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((unit_index == '0) || !age_valid) |->
    !((unit_index == '0) && age_valid) && (age_valid || (age_ticks == '0)))
    else $error("bad age report");

endmodule

bind windowed_min_max_sum_monitor_core wmms_checker u_wmms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .unit_index   (out_ch.unit_index),
  .sample_count (out_ch.sample_count),
  .age_ticks    (out_ch.age_ticks),
  .age_valid    (out_ch.age_valid),
  .error_code   (out_ch.error_code),
  .last_result  (out_ch.last_result)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for windowed_min_max_sum_monitor_core
// Drives operations on the input channel with random gaps and stalls on the
// result channel. A local model of the statistic units, the timer and the
// window timeouts predicts every status and read result, and each result
// transfer is checked field by field against the oldest prediction. Directed
// tests cover extremes, timer misuse, saturation, wrap, rotation and register
// writes. Random phases then run under several timeout settings.
// ----------------------------------------------------------------------------
module tb;
  import wmms_pkg::*;

  localparam int NUM_UNITS   = 5;
  localparam int HOLD_OFF    = 6;     // cycles past the last result before idle
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int PHASE_ITEMS = 34;

  localparam logic [OPCODE_W-1:0]  OP_UNUSED_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0]  OP_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;
  localparam logic [TICK_W-1:0]    TICK_MAX        = '1;

  logic clk;
  logic rst_n;

  wmms_in_if  in_ch ();
  wmms_out_if out_ch ();
  wmms_cfg_if cfg_ch ();

  windowed_min_max_sum_monitor_core #(
    .NUM_WINDOWS(2)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the block state
  unit_t       units [NUM_UNITS];
  logic        timer_on;
  logic [31:0] timer_t0;
  logic [31:0] tmo_short;
  logic [31:0] tmo_long;

  res_t pending_reports [$];

  int   mismatch_count;
  int   items_sent;
  int   reports_checked;
  int   reg_writes;
  int   idle_cycles;
  bit   steady;          // no gaps and no stalls while set
  logic [TICK_W-1:0] tick_now;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void model_reset();
    for (int u = 0; u < NUM_UNITS; u++) units[u] = UNIT_CLEAR;
    timer_on  = 1'b0;
    timer_t0  = '0;
    tmo_short = TIMEOUT_SHORT_RST;
    tmo_long  = TIMEOUT_LONG_RST;
  endfunction

  function automatic void add_sample(logic signed [VALUE_W-1:0] v, logic [TAG_W-1:0] tag);
    for (int u = 0; u < NUM_UNITS; u++) begin
      if (units[u].count != COUNT_MAX) units[u].count = units[u].count + 1'b1;
      units[u].sum = units[u].sum + {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
      if ($signed(v) < $signed(units[u].min_v)) begin
        units[u].min_v   = v;
        units[u].min_tag = tag;
      end
      if ($signed(v) > $signed(units[u].max_v)) begin
        units[u].max_v   = v;
        units[u].max_tag = tag;
      end
    end
  endfunction

  function automatic res_t status_report(err_t e);
    res_t r;
    r = '0;
    r.error_code  = e;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic res_t unit_report(int u, logic [IDX_W-1:0] idx, logic [TICK_W-1:0] now,
                                       logic last);
    res_t r;
    r.unit_index   = idx;
    r.sample_count = units[u].count;
    r.value_sum    = units[u].sum;
    r.min_value    = units[u].min_v;
    r.max_value    = units[u].max_v;
    r.min_tag      = units[u].min_tag;
    r.max_tag      = units[u].max_tag;
    r.age_valid    = (units[u].start != '0);
    r.age_ticks    = r.age_valid ? now - units[u].start : '0;
    r.error_code   = ERR_OK;
    r.last_result  = last;
    return r;
  endfunction

  // applies one accepted operation and queues the reports it causes
  function automatic void apply_op(in_item_t it);
    logic [TICK_W-1:0]  elapsed;
    logic [TICK_W-1:0]  tmo;
    logic [TICK_W:0]    deadline;
    int                 prv;
    int                 cur;
    case (it.opcode)
      OP_SAMPLE: add_sample(it.sample_value, it.sample_tag);
      OP_TIMER_START: begin
        if (timer_on) begin
          pending_reports.push_back(status_report(ERR_RUNNING));
        end else begin
          timer_on = 1'b1;
          timer_t0 = it.now_ticks;
          pending_reports.push_back(status_report(ERR_OK));
        end
      end
      OP_TIMER_STOP: begin
        if (!timer_on) begin
          pending_reports.push_back(status_report(ERR_NOT_RUNNING));
        end else begin
          elapsed = it.now_ticks - timer_t0;
          // elapsed time saturates to the largest signed value
          add_sample(elapsed[TICK_W-1] ? VALUE_MAX : elapsed, it.sample_tag);
          timer_on = 1'b0;
          pending_reports.push_back(status_report(ERR_OK));
        end
      end
      OP_ROTATE: begin
        for (int w = 0; w < 2; w++) begin
          prv = 1 + 2 * w;
          cur = 2 + 2 * w;
          tmo = (w == 0) ? tmo_short : tmo_long;
          deadline = {1'b0, units[cur].start} + {1'b0, tmo};
          if (deadline <= {1'b0, it.now_ticks}) begin
            units[prv] = units[cur];
            units[cur] = UNIT_CLEAR;
            units[cur].start = it.now_ticks;
          end
        end
      end
      OP_READ: begin
        pending_reports.push_back(unit_report(0, 2'd0, it.now_ticks, 1'b0));
        pending_reports.push_back(unit_report(1, 2'd1, it.now_ticks, 1'b0));
        pending_reports.push_back(unit_report(3, 2'd2, it.now_ticks, 1'b1));
      end
      default: ;  // unused opcodes are ignored
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_report(res_t got);
    res_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("result with nothing pending, unit_index", got.unit_index, 0);
    end else begin
      want = pending_reports.pop_front();
      if (got.unit_index   !== want.unit_index)
        report_mismatch("unit_index", got.unit_index, want.unit_index);
      if (got.sample_count !== want.sample_count)
        report_mismatch("sample_count", got.sample_count, want.sample_count);
      if (got.value_sum    !== want.value_sum)
        report_mismatch("value_sum", got.value_sum, want.value_sum);
      if (got.min_value    !== want.min_value)
        report_mismatch("min_value", got.min_value, want.min_value);
      if (got.max_value    !== want.max_value)
        report_mismatch("max_value", got.max_value, want.max_value);
      if (got.min_tag      !== want.min_tag)
        report_mismatch("min_tag", got.min_tag, want.min_tag);
      if (got.max_tag      !== want.max_tag)
        report_mismatch("max_tag", got.max_tag, want.max_tag);
      if (got.age_ticks    !== want.age_ticks)
        report_mismatch("age_ticks", got.age_ticks, want.age_ticks);
      if (got.age_valid    !== want.age_valid)
        report_mismatch("age_valid", got.age_valid, want.age_valid);
      if (got.error_code   !== want.error_code)
        report_mismatch("error_code", got.error_code, want.error_code);
      if (got.last_result  !== want.last_result)
        report_mismatch("last_result", got.last_result, want.last_result);
    end
    reports_checked++;
  endtask

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.unit_index   = out_ch.unit_index;
      got.sample_count = out_ch.sample_count;
      got.value_sum    = out_ch.value_sum;
      got.min_value    = out_ch.min_value;
      got.max_value    = out_ch.max_value;
      got.min_tag      = out_ch.min_tag;
      got.max_tag      = out_ch.max_tag;
      got.age_ticks    = out_ch.age_ticks;
      got.age_valid    = out_ch.age_valid;
      got.error_code   = out_ch.error_code;
      got.last_result  = out_ch.last_result;
      check_report(got);
    end
  end

  // result side: random stall before each transfer
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // watchdog: ends a run in which nothing moves
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] v,
                           logic [TAG_W-1:0] tag, logic [TICK_W-1:0] now);
    int       gap;
    in_item_t it;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_value <= v;
    in_ch.sample_tag   <= tag;
    in_ch.now_ticks    <= now;
    do @(posedge clk); while (!in_ch.ready);
    it.opcode       = op;
    it.sample_value = v;
    it.sample_tag   = tag;
    it.now_ticks    = now;
    apply_op(it);
    items_sent++;
  endtask

  // lets every pending result arrive, then the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_TIMEOUT_SHORT) tmo_short = data;
    else if (idx == CFG_TIMEOUT_LONG) tmo_long = data;
    reg_writes++;
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return VALUE_MAX;
    if (sel == 1) return VALUE_MIN;
    if (sel < 5) return $signed($urandom_range(0, 200)) - 100;
    return $urandom();
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_state();
    send_item(OP_READ, 0, 0, 32'd0);
    send_item(OP_READ, 0, 0, 32'd7);
  endtask

  task automatic test_extremes();
    // equal to the empty extreme: neither value nor tag changes
    send_item(OP_SAMPLE, VALUE_MAX, 8'h01, 32'd1);
    send_item(OP_SAMPLE, VALUE_MIN, 8'h02, 32'd1);
    send_item(OP_SAMPLE, 32'sd5, 8'h03, 32'd1);
    send_item(OP_SAMPLE, 32'sd5, 8'h04, 32'd1);
    send_item(OP_SAMPLE, -32'sd7, 8'hff, 32'd1);
    send_item(OP_READ, 0, 0, 32'd1);
  endtask

  task automatic test_timer();
    send_item(OP_TIMER_STOP, 0, 8'h11, 32'd90);          // not running
    send_item(OP_TIMER_START, 0, 0, 32'd100);
    send_item(OP_TIMER_START, 0, 0, 32'd110);             // already running
    send_item(OP_TIMER_STOP, 0, 8'haa, 32'd130);
    send_item(OP_TIMER_START, 0, 0, 32'h0000_0010);
    send_item(OP_TIMER_STOP, 0, 8'h55, 32'h9000_0000);    // saturates
    send_item(OP_TIMER_START, 0, 0, 32'hffff_fff0);
    send_item(OP_TIMER_STOP, 0, 8'h66, 32'h0000_0010);    // wraps
  endtask

  task automatic test_rotate();
    send_item(OP_ROTATE, 0, 0, 32'd1);                    // before any timeout
    send_item(OP_ROTATE, 0, 0, 32'd2);                    // short window only
    send_item(OP_SAMPLE, 32'sd42, 8'h42, 32'd3);
    send_item(OP_ROTATE, 0, 0, 32'd12);                   // both windows
    send_item(OP_READ, 0, 0, 32'd20);
  endtask

  task automatic test_unused_ops();
    send_item(OP_UNUSED_FIRST, 32'sd9, 8'h09, 32'd21);
    send_item(OP_UNUSED_LAST, 32'sd9, 8'h09, 32'd21);
  endtask

  task automatic test_registers();
    write_reg(CFG_TIMEOUT_SHORT, TICK_MAX);
    write_reg(CFG_TIMEOUT_LONG, 32'd1);
    write_reg(CFG_UNMAPPED, 32'd0);                       // no register here
    write_reg(CFG_UNMAPPED_HI, 32'h1234_5678);
    send_item(OP_ROTATE, 0, 0, 32'd40);
    send_item(OP_SAMPLE, -32'sd3, 8'h33, 32'd41);
    send_item(OP_READ, 0, 0, 32'd50);
  endtask

  task automatic test_random_phase(logic [31:0] short_t, logic [31:0] long_t, bit no_idle);
    int                sel;
    logic [OPCODE_W-1:0] op;
    write_reg(CFG_TIMEOUT_SHORT, short_t);
    write_reg(CFG_TIMEOUT_LONG, long_t);
    steady = no_idle;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 44)      op = OP_SAMPLE;
      else if (sel < 56) op = OP_TIMER_START;
      else if (sel < 68) op = OP_TIMER_STOP;
      else if (sel < 84) op = OP_ROTATE;
      else if (sel < 98) op = OP_READ;
      else               op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      // time mostly moves forward, now and then it jumps anywhere
      if ($urandom_range(0, 19) == 0) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(0, 6);
      send_item(op, rand_value(), TAG_W'($urandom_range(0, 255)), tick_now);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    mismatch_count  = 0;
    items_sent      = 0;
    reports_checked = 0;
    reg_writes      = 0;
    idle_cycles     = 0;
    steady          = 1'b0;
    tick_now        = 32'd100;
    model_reset();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_SAMPLE;
    in_ch.sample_value <= '0;
    in_ch.sample_tag   <= '0;
    in_ch.now_ticks    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_TIMEOUT_SHORT;
    cfg_ch.data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extremes();
    test_timer();
    test_rotate();
    test_unused_ops();
    test_registers();

    test_random_phase(TIMEOUT_SHORT_RST, TIMEOUT_LONG_RST, 1'b0);
    test_random_phase(32'd1, 32'd1, 1'b1);
    test_random_phase(TICK_MAX, TICK_MAX, 1'b0);
    test_random_phase($urandom_range(1, 40), $urandom_range(1, 200), 1'b0);

    drain();
    $display("Sent %0d operations, checked %0d results, %0d register writes",
             items_sent, reports_checked, reg_writes);
    $display("Covered extremes, timer errors, saturation, wrap, rotation, unused codes");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
